// File: hw/rtl/sobel_pkg.sv
// Shared widths, reset values, register indexes and stage tag for the Sobel edge block.
// No dependencies; imported by sobel_root and sobel_edge_magnitude.
package sobel_pkg;

  localparam int PIX_W         = 8;   // gray pixel and magnitude width
  localparam int CFG_W         = 12;  // configuration register width
  localparam int ROW_W         = 12;  // row counter width
  localparam int GRAD_W        = 11;  // signed gradient, |g| <= 1020
  localparam int ABS_W         = 10;  // gradient magnitude
  localparam int SQ_W          = 20;  // squared gradient magnitude
  localparam int SUM_W         = 21;  // gx^2 + gy^2
  localparam int RAD_W         = 16;  // radicand seen by the root stages
  localparam int ROOT_W        = 8;   // root width, one stage per bit
  localparam int REM_W         = 11;  // partial remainder of the root
  localparam int CFG_IDX_W     = 1;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] GEOM_MIN   = CFG_W'(3);

  localparam logic [PIX_W-1:0] MAG_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // travels with each item down the arithmetic pipeline
  typedef struct packed {
    logic res;   // item produces a result
    logic last;  // last result of the frame
  } tag_t;

endpackage

// File: hw/rtl/sobel_root.sv
// Pipelined saturating integer square root, one result bit per stage.
// Depends on sobel_pkg (widths, tag_t, MAG_MAX).
module sobel_root (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  sobel_pkg::tag_t                in_tag,
  input  logic [sobel_pkg::SUM_W-1:0]    in_sum,
  output sobel_pkg::tag_t                out_tag,
  output logic [sobel_pkg::PIX_W-1:0]    out_mag
);
  import sobel_pkg::*;

  localparam int ST = ROOT_W;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, top pair first
  } step_t;

  function automatic step_t root_step(step_t s);
    step_t            o;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
    trial  = REM_W'({s.root, 2'b01});
    o.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  step_t stg_r   [ST];
  step_t stg_nxt [ST];
  logic  sat_r   [ST];
  tag_t  tag_r   [ST];

  always_comb begin
    step_t src;
    src.rem  = '0;
    src.root = '0;
    src.rad  = in_sum[RAD_W-1:0];
    stg_nxt[0] = root_step(src);
    for (int i = 1; i < ST; i++) begin
      stg_nxt[i] = root_step(stg_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) begin
        tag_r[i] <= '0;
      end
    end else if (en) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < ST; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= |in_sum[SUM_W-1:RAD_W];
      for (int i = 1; i < ST; i++) begin
        sat_r[i] <= sat_r[i-1];
      end
      for (int i = 0; i < ST; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_tag = tag_r[ST-1];
  // sums of 65536 and above clamp; 65025..65535 already root to the maximum
  assign out_mag = sat_r[ST-1] ? MAG_MAX : stg_r[ST-1].root;

endmodule

// File: hw/rtl/sobel_edge_magnitude.sv
// Top level of the 3x3 Sobel edge magnitude block: line stores, window, gradients, squares.
// Depends on sobel_pkg and sobel_root.
//
//  port group  | dir | payload                        | handshake
//  in_*        | in  | tdata[7:0] gray_pixel          | tvalid / tready
//  out_*       | out | tdata[7:0] edge_magnitude,     | tvalid / tready
//              |     | tlast frame_end                |
//  cfg_*       | in  | addr: 0 width, 1 height, wdata | we, no read-back
//
// One item per clock, except while the output register holds an untaken result.
// The line stores are read in the accept cycle and written back when the item
// leaves stage one, one port each, so consecutive items never touch the same column.
// A single enable advances every stage; the block stalls only while the output
// register holds an untaken result. Reset is synchronous, active low; the line
// stores are not cleared, since the first two rows of a frame fill them.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sobel_pkg::PIX_W-1:0]        in_tdata,   // [7:0] gray_pixel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sobel_pkg::PIX_W-1:0]        out_tdata,  // [7:0] edge_magnitude
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [sobel_pkg::CFG_W-1:0]        cfg_wdata
);
  import sobel_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  function automatic logic signed [GRAD_W-1:0] ext(logic [PIX_W-1:0] v);
    return $signed({{(GRAD_W-PIX_W){1'b0}}, v});
  endfunction

  // configuration and counters
  logic [CFG_W-1:0] width_r, height_r;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [EW-1:0]    width_x, weff_x;
  logic [AW:0]      w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             wrap, x_last, y_last;
  logic [AW-1:0]    x_cur;
  logic [ROW_W-1:0] y_pre, y_cur;
  tag_t             tag_cur;

  logic adv, in_fire;

  // stage 1: memory read in flight
  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic             s1_item_r;
  tag_t             s1_tag_r;
  logic [AW-1:0]    s1_x_r;
  logic [PIX_W-1:0] s1_pix_r, rd_up_r, rd_mid_r;
  logic [PIX_W-1:0] wc_r [6];

  // stage 2..4
  logic signed [GRAD_W-1:0] gx, gy, gx_neg, gy_neg;
  logic [ABS_W-1:0]         ax_nxt, ay_nxt, ax_r, ay_r;
  tag_t                     s2_tag_r, s3_tag_r, s4_tag_r;
  logic [SQ_W-1:0]          axsq_r, aysq_r;
  logic [SUM_W-1:0]         sum_r;

  tag_t             rt_tag;
  logic [PIX_W-1:0] rt_mag;
  logic             out_tvalid_r, out_last_r;
  logic [PIX_W-1:0] out_mag_r;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;

  // effective geometry
  assign width_x = EW'(width_r);
  always_comb begin
    if (width_x < EW'(3)) begin
      weff_x = EW'(3);
    end else if (width_x > EW'(MAX_WIDTH)) begin
      weff_x = EW'(MAX_WIDTH);
    end else begin
      weff_x = width_x;
    end
  end
  assign w_eff = weff_x[AW:0];
  assign h_eff = (height_r < GEOM_MIN) ? GEOM_MIN : height_r;

  // position of the incoming pixel; wrap covers counters left past a new geometry
  assign wrap   = {1'b0, col_r} >= w_eff;
  assign x_cur  = wrap ? '0 : col_r;
  assign y_pre  = wrap ? row_r + ROW_W'(1) : row_r;
  assign y_cur  = (y_pre >= h_eff) ? '0 : y_pre;
  assign x_last = ({1'b0, x_cur} + (AW+1)'(1)) == w_eff;
  assign y_last = (y_cur + ROW_W'(1)) == h_eff;

  assign tag_cur.res  = (x_cur >= AW'(2)) && (y_cur >= ROW_W'(2));
  assign tag_cur.last = x_last && y_last;

  always_comb begin
    col_nxt = x_cur + AW'(1);
    row_nxt = y_cur;
    if (x_last) begin
      col_nxt = '0;
      row_nxt = y_last ? '0 : y_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: read at accept, write back as the item leaves stage one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_up_r  <= up_mem[x_cur];
      rd_mid_r <= mid_mem[x_cur];
    end
    if (adv && s1_item_r) begin
      up_mem[s1_x_r]  <= rd_mid_r;
      mid_mem[s1_x_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r   <= x_cur;
      s1_pix_r <= in_tdata;
    end
  end

  // gradients over the window; column order oldest, previous, incoming
  always_comb begin
    gx = (ext(rd_up_r) - ext(wc_r[0]))
       + ((ext(rd_mid_r) - ext(wc_r[1])) <<< 1)
       + (ext(s1_pix_r) - ext(wc_r[2]));
    gy = (ext(wc_r[2]) - ext(wc_r[0]))
       + ((ext(wc_r[5]) - ext(wc_r[3])) <<< 1)
       + (ext(s1_pix_r) - ext(rd_up_r));
    gx_neg = -gx;
    gy_neg = -gy;
    ax_nxt = gx[GRAD_W-1] ? gx_neg[ABS_W-1:0] : gx[ABS_W-1:0];
    ay_nxt = gy[GRAD_W-1] ? gy_neg[ABS_W-1:0] : gy[ABS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r    <= 1'b0;
      s1_tag_r     <= '0;
      s2_tag_r     <= '0;
      s3_tag_r     <= '0;
      s4_tag_r     <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (adv) begin
      s1_item_r    <= in_fire;
      s1_tag_r     <= in_fire ? tag_cur : '0;
      s2_tag_r     <= s1_tag_r;
      s3_tag_r     <= s2_tag_r;
      s4_tag_r     <= s3_tag_r;
      out_tvalid_r <= rt_tag.res;
      // advance the window by one column
      if (s1_item_r) begin
        wc_r[0] <= wc_r[3];
        wc_r[1] <= wc_r[4];
        wc_r[2] <= wc_r[5];
        wc_r[3] <= rd_up_r;
        wc_r[4] <= rd_mid_r;
        wc_r[5] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r       <= ax_nxt;
      ay_r       <= ay_nxt;
      axsq_r     <= SQ_W'(ax_r) * SQ_W'(ax_r);
      aysq_r     <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sum_r      <= SUM_W'(axsq_r) + SUM_W'(aysq_r);
      out_mag_r  <= rt_mag;
      out_last_r <= rt_tag.last;
    end
  end

  sobel_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_tag  (s4_tag_r),
    .in_sum  (sum_r),
    .out_tag (rt_tag),
    .out_mag (rt_mag)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_mag_r;
  assign out_tlast  = out_last_r;

  // read and write-back of the line stores never meet on one column
  a_no_col_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_item_r) |-> (x_cur != s1_x_r))
    else $error("line store read and write-back hit the same column");

  // frame end only on an interior pixel
  a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && tag_cur.last) |-> tag_cur.res)
    else $error("frame end flagged on a border pixel");

  // a result in stage one comes from an accepted item
  a_res_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tag_r.res |-> s1_item_r)
    else $error("result tag without an item");

  // a stall freezes the output register
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_mag_r)))
    else $error("output register changed during a stall");

endmodule
